/* design/bbum_pkg.sv */
// Shared constants, types and helpers of the box blur unsharp mask block.
package bbum_pkg;

   localparam int DEF_KERNEL    = 3;
   localparam int DEF_MAX_WIDTH = 1024;
   localparam int MAX_HEIGHT    = 1024;
   localparam int MIN_DIM       = 3;

   localparam int CH_W     = 8;
   localparam int CH_COUNT = 3;
   localparam int PIX_W    = CH_W * CH_COUNT;
   localparam int CH_MAX   = 255;

   localparam int CFG_DIM_W  = 11;
   localparam int GAIN_W     = 12;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   localparam int RST_WIDTH  = 640;
   localparam int RST_HEIGHT = 480;
   localparam int RST_GAIN   = 256;

   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int FH_W  = $clog2(MAX_HEIGHT + 1);

   // gain is Q4.8: product carries 8 fraction bits
   localparam int GAIN_FRAC  = 8;
   localparam int ROUND_HALF = 128;

   localparam int JOB_DEPTH = 4;
   localparam int OUT_DEPTH = 16;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_SHARPEN_GAIN = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic inner;
      logic frame_end;
   } job_flags_type;

   function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] p, input int idx);
      chan = p[(CH_COUNT - 1 - idx) * CH_W +: CH_W];
   endfunction

endpackage

/* design/bbum_fifo.sv */
// Small register FIFO; the caller never pushes into a full queue.
module bbum_fifo import bbum_pkg::*; #(
   parameter int WIDTH = PIX_W,
   parameter int DEPTH = OUT_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_pop;

   assign empty     = (count_ff == '0);
   assign do_pop    = pop && !empty;
   assign head_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* design/bbum_front.sv */
// Front end: request classification, frame counters, pixel delay line, line buffers, column sums.
module bbum_front import bbum_pkg::*; #(
   parameter int KERNEL    = DEF_KERNEL,
   parameter int MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int SUM_W    = $clog2(KERNEL * KERNEL * CH_MAX + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic                             cmd,
   input  logic [PIX_W-1:0]                 pixel,
   input  logic [CFG_DIM_W-1:0]             image_width,
   input  logic [CFG_DIM_W-1:0]             image_height,
   output logic                             emit,
   output logic                             job_valid,
   output logic [CH_COUNT-1:0][SUM_W-1:0]   job_sum,
   output logic [PIX_W-1:0]                 job_src,
   output job_flags_type                    job_flags
);

   localparam int HALF      = KERNEL / 2;
   localparam int TAIL      = KERNEL - 1 - KERNEL / 2;
   localparam int COL_W     = $clog2(MAX_WIDTH);
   localparam int FW_W      = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W     = (FW_W > CFG_DIM_W) ? FW_W : CFG_DIM_W;
   localparam int DLY_DEPTH = TAIL * MAX_WIDTH + TAIL + 1;
   localparam int DLY_AW    = $clog2(DLY_DEPTH);
   localparam int PEND_W    = $clog2(DLY_DEPTH + 1);
   localparam int COLS_W    = $clog2(KERNEL * CH_MAX + 1);
   localparam int FW_RST    = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
   localparam int LA_RST    = TAIL * FW_RST + TAIL;

   // input side state
   logic [COL_W-1:0]  in_col_ff, in_col_in, out_col_ff, out_col_in;
   logic [ROW_W-1:0]  in_row_ff, in_row_in, out_row_ff, out_row_in;
   logic [FW_W-1:0]   fw_ff, fw_in, fw_cfg, fw_use;
   logic [FH_W-1:0]   fh_ff, fh_in, fh_cfg, fh_use;
   logic [PEND_W-1:0] la_ff, la_in, la_cfg, la_use;
   logic [PEND_W-1:0] pend_ff, pend_in;
   logic [DLY_AW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CMP_W-1:0]  w_ext;
   logic              at_boundary, is_pix, latch_size;
   job_flags_type     a_flags;

   // pipeline stages
   logic                         b_pix_ff, b_emit_ff, c_emit_ff;
   logic [PIX_W-1:0]             b_pixel_ff, src_rd_ff, c_src_ff;
   logic [COL_W-1:0]             b_col_ff;
   job_flags_type                b_flags_ff, c_flags_ff;
   logic [KERNEL-2:0][PIX_W-1:0] line_rd_ff;
   logic [KERNEL-2:0][PIX_W-1:0] line_wr;
   logic [COLS_W-1:0]            colsum_ff [CH_COUNT][KERNEL];
   logic [COLS_W-1:0]            col_new   [CH_COUNT];

   logic [PIX_W-1:0] dly_mem [DLY_DEPTH];

   always_comb begin
      w_ext = CMP_W'(image_width);
      if (w_ext < CMP_W'(MIN_DIM)) begin
         fw_cfg = FW_W'(MIN_DIM);
      end else if (w_ext > CMP_W'(MAX_WIDTH)) begin
         fw_cfg = FW_W'(MAX_WIDTH);
      end else begin
         fw_cfg = FW_W'(w_ext);
      end
      if (image_height < CFG_DIM_W'(MIN_DIM)) begin
         fh_cfg = FH_W'(MIN_DIM);
      end else if (image_height > CFG_DIM_W'(MAX_HEIGHT)) begin
         fh_cfg = FH_W'(MAX_HEIGHT);
      end else begin
         fh_cfg = FH_W'(image_height);
      end
      la_cfg = PEND_W'(TAIL) * PEND_W'(fw_cfg) + PEND_W'(TAIL);
   end

   always_comb begin
      at_boundary = (in_row_ff == '0) && (in_col_ff == '0);
      is_pix      = accept && (cmd == CMD_PIXEL);
      latch_size  = is_pix && at_boundary && (pend_ff == '0);
      fw_use      = latch_size ? fw_cfg : fw_ff;
      fh_use      = latch_size ? fh_cfg : fh_ff;
      la_use      = latch_size ? la_cfg : la_ff;

      if (is_pix) begin
         emit = (pend_ff >= la_use);
      end else begin
         emit = accept && (cmd == CMD_FLUSH) && at_boundary && (pend_ff != '0);
      end

      a_flags.inner =
         (out_row_ff >= ROW_W'(HALF)) &&
         ((FH_W + 1)'(out_row_ff) + (FH_W + 1)'(TAIL) < (FH_W + 1)'(fh_use)) &&
         (out_col_ff >= COL_W'(HALF)) &&
         ((FW_W + 1)'(out_col_ff) + (FW_W + 1)'(TAIL) < (FW_W + 1)'(fw_use));
      a_flags.frame_end = (FH_W'(out_row_ff) == fh_use - FH_W'(1)) &&
                          (FW_W'(out_col_ff) == fw_use - FW_W'(1));

      fw_in      = fw_use;
      fh_in      = fh_use;
      la_in      = la_use;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      wr_ptr_in  = wr_ptr_ff;
      rd_ptr_in  = rd_ptr_ff;
      pend_in    = pend_ff;

      if (is_pix) begin
         wr_ptr_in = (wr_ptr_ff == DLY_AW'(DLY_DEPTH - 1)) ? '0 : wr_ptr_ff + DLY_AW'(1);
         if (FW_W'(in_col_ff) + FW_W'(1) == fw_use) begin
            in_col_in = '0;
            in_row_in = (FH_W'(in_row_ff) + FH_W'(1) == fh_use) ? '0 : in_row_ff + ROW_W'(1);
         end else begin
            in_col_in = in_col_ff + COL_W'(1);
         end
      end
      if (emit) begin
         rd_ptr_in = (rd_ptr_ff == DLY_AW'(DLY_DEPTH - 1)) ? '0 : rd_ptr_ff + DLY_AW'(1);
         if (FW_W'(out_col_ff) + FW_W'(1) == fw_use) begin
            out_col_in = '0;
            out_row_in = (FH_W'(out_row_ff) + FH_W'(1) == fh_use) ? '0 :
                         out_row_ff + ROW_W'(1);
         end else begin
            out_col_in = out_col_ff + COL_W'(1);
         end
      end
      if (is_pix && !emit) begin
         pend_in = pend_ff + PEND_W'(1);
      end else if (!is_pix && emit) begin
         pend_in = pend_ff - PEND_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= FW_W'(FW_RST);
         fh_ff      <= FH_W'(RST_HEIGHT);
         la_ff      <= PEND_W'(LA_RST);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         pend_ff    <= '0;
         b_pix_ff   <= 1'b0;
         b_emit_ff  <= 1'b0;
         c_emit_ff  <= 1'b0;
      end else begin
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         la_ff      <= la_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
         wr_ptr_ff  <= wr_ptr_in;
         rd_ptr_ff  <= rd_ptr_in;
         pend_ff    <= pend_in;
         b_pix_ff   <= is_pix;
         b_emit_ff  <= emit;
         c_emit_ff  <= b_emit_ff;
      end
   end

   // pixel delay line: the oldest pending pixel is the source of the next result
   always_ff @(posedge clock) begin
      if (is_pix) begin
         dly_mem[wr_ptr_ff] <= pixel;
      end
      if (emit) begin
         src_rd_ff <= dly_mem[rd_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      b_pixel_ff <= pixel;
      b_col_ff   <= in_col_ff;
      b_flags_ff <= a_flags;
      c_flags_ff <= b_flags_ff;
      c_src_ff   <= src_rd_ff;
   end

   // line buffers indexed by column; line j holds the row j+1 above
   for (genvar j = 0; j < KERNEL - 1; j++) begin : g_line
      logic [PIX_W-1:0] line_mem [MAX_WIDTH];

      if (j == 0) begin : g_first
         assign line_wr[j] = b_pixel_ff;
      end else begin : g_next
         assign line_wr[j] = line_rd_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (is_pix) begin
            line_rd_ff[j] <= line_mem[in_col_ff];
         end
         if (b_pix_ff) begin
            line_mem[b_col_ff] <= line_wr[j];
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         col_new[ch] = COLS_W'(chan(b_pixel_ff, ch));
         for (int j = 0; j < KERNEL - 1; j++) begin
            col_new[ch] = col_new[ch] + COLS_W'(chan(line_rd_ff[j], ch));
         end
      end
   end

   // window of column sums advances one column per pixel
   always_ff @(posedge clock) begin
      if (b_pix_ff) begin
         for (int ch = 0; ch < CH_COUNT; ch++) begin
            colsum_ff[ch][0] <= col_new[ch];
            for (int k = 1; k < KERNEL; k++) begin
               colsum_ff[ch][k] <= colsum_ff[ch][k-1];
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         job_sum[ch] = '0;
         for (int k = 0; k < KERNEL; k++) begin
            job_sum[ch] = job_sum[ch] + SUM_W'(colsum_ff[ch][k]);
         end
      end
   end

   assign job_valid = c_emit_ff;
   assign job_src   = c_src_ff;
   assign job_flags = c_flags_ff;

endmodule

/* design/bbum_back.sv */
// Back end: box mean by reciprocal, positive difference, gain, rounding and clamp; non-inner pixels pass through.
module bbum_back import bbum_pkg::*; #(
   parameter int KERNEL = DEF_KERNEL,
   localparam int SUM_W = $clog2(KERNEL * KERNEL * CH_MAX + 1)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   input  logic [CH_COUNT-1:0][SUM_W-1:0] job_sum,
   input  logic [PIX_W-1:0]               job_src,
   input  job_flags_type                  job_flags,
   input  logic [GAIN_W-1:0]              sharpen_gain,
   output logic                           res_valid,
   output logic [PIX_W-1:0]               res_pixel,
   output logic                           res_frame_end
);

   localparam int DIV_D   = KERNEL * KERNEL;
   localparam int DIV_L   = $clog2(DIV_D);
   localparam int DIV_S   = SUM_W + DIV_L;
   localparam int RECIP_W = SUM_W + 2;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << DIV_S) + 64'(DIV_D) - 64'd1) / 64'(DIV_D);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam int GP_W  = GAIN_W + CH_W;
   localparam int INC_W = GP_W + 1 - GAIN_FRAC;
   localparam int TOT_W = INC_W + 1;

   logic                           v1_ff, v2_ff, v3_ff, v4_ff;
   logic [CH_COUNT-1:0][SUM_W-1:0] s1_sum_ff;
   logic [CH_COUNT-1:0][PROD_W-1:0] s2_prod_ff;
   logic [CH_COUNT-1:0][CH_W-1:0]  s3_diff_ff;
   logic [CH_COUNT-1:0][GP_W-1:0]  s4_gp_ff;
   logic [PIX_W-1:0]               s1_src_ff, s2_src_ff, s3_src_ff, s4_src_ff;
   job_flags_type                  s1_flags_ff, s2_flags_ff, s3_flags_ff, s4_flags_ff;
   logic [CH_W-1:0]                blur   [CH_COUNT];
   logic [GP_W:0]                  rnd    [CH_COUNT];
   logic [TOT_W-1:0]               tot    [CH_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= job_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         blur[ch] = s2_prod_ff[ch][DIV_S +: CH_W];
      end
   end

   always_ff @(posedge clock) begin
      s1_sum_ff   <= job_sum;
      s1_src_ff   <= job_src;
      s1_flags_ff <= job_flags;
      s2_src_ff   <= s1_src_ff;
      s2_flags_ff <= s1_flags_ff;
      s3_src_ff   <= s2_src_ff;
      s3_flags_ff <= s2_flags_ff;
      s4_src_ff   <= s3_src_ff;
      s4_flags_ff <= s3_flags_ff;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         s2_prod_ff[ch] <= PROD_W'(s1_sum_ff[ch]) * PROD_W'(RECIP);
         // drop negative differences
         s3_diff_ff[ch] <= (chan(s2_src_ff, ch) > blur[ch]) ?
                           chan(s2_src_ff, ch) - blur[ch] : '0;
         s4_gp_ff[ch]   <= GP_W'(sharpen_gain) * GP_W'(s3_diff_ff[ch]);
      end
   end

   always_comb begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         rnd[ch] = (GP_W + 1)'(s4_gp_ff[ch]) + (GP_W + 1)'(ROUND_HALF);
         tot[ch] = TOT_W'(chan(s4_src_ff, ch)) + TOT_W'(rnd[ch][GP_W:GAIN_FRAC]);
         if (!s4_flags_ff.inner) begin
            res_pixel[(CH_COUNT - 1 - ch) * CH_W +: CH_W] = chan(s4_src_ff, ch);
         end else if (tot[ch] > TOT_W'(CH_MAX)) begin
            res_pixel[(CH_COUNT - 1 - ch) * CH_W +: CH_W] = CH_W'(CH_MAX);
         end else begin
            res_pixel[(CH_COUNT - 1 - ch) * CH_W +: CH_W] = tot[ch][CH_W-1:0];
         end
      end
   end

   assign res_valid     = v4_ff;
   assign res_frame_end = s4_flags_ff.frame_end;

endmodule

/* design/box_blur_unsharp_mask.sv */
// Box blur unsharp mask for an RGB888 raster stream. One request (pixel or flush) is taken per
// clock; the input side stalls only when the results already promised (in flight plus waiting
// in the OUT_DEPTH-entry output queue) reach OUT_DEPTH. A pixel result released by a request passes
// through two front stages (pixel delay memory and line buffer reads, column sums with the window
// sum formed as the job is queued), the job queue, four back stages (reciprocal multiply,
// difference, gain multiply, round and clamp) and the output queue.
// A result is released once (KERNEL-1-KERNEL/2) rows plus as many pixels have followed it;
// flushes drain a finished frame's tail.
// Frame size is latched at the first pixel of a frame when nothing is pending.
module box_blur_unsharp_mask import bbum_pkg::*; #(
   parameter int KERNEL    = DEF_KERNEL,
   parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  logic                  req_cmd,
   input  logic [CH_W-1:0]       req_red_in,
   input  logic [CH_W-1:0]       req_green_in,
   input  logic [CH_W-1:0]       req_blue_in,
   output logic                  empty,
   input  logic                  pop,
   output logic [CH_W-1:0]       rsp_red_out,
   output logic [CH_W-1:0]       rsp_green_out,
   output logic [CH_W-1:0]       rsp_blue_out,
   output logic                  rsp_frame_end,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SUM_W  = $clog2(KERNEL * KERNEL * CH_MAX + 1);
   localparam int JOB_W  = CH_COUNT * SUM_W + PIX_W + $bits(job_flags_type);
   localparam int RES_W  = PIX_W + 1;
   localparam int CRED_W = $clog2(OUT_DEPTH + 1);

   logic [CFG_DIM_W-1:0] width_ff, height_ff;
   logic [GAIN_W-1:0]    gain_ff;
   logic [CRED_W-1:0]    credit_ff, credit_in;
   logic                 accept, emit, rsp_take;

   logic                           fr_valid, bk_valid, jq_empty, res_valid, res_frame_end;
   logic [CH_COUNT-1:0][SUM_W-1:0] fr_sum, bk_sum;
   logic [PIX_W-1:0]               fr_src, bk_src, res_pixel;
   job_flags_type                  fr_flags, bk_flags;
   logic [JOB_W-1:0]               jq_head;
   logic [RES_W-1:0]               oq_head;

   assign csr_ready = 1'b1;
   assign accept    = push && !full;
   assign rsp_take  = pop && !empty;
   assign full      = (credit_ff == CRED_W'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(RST_WIDTH);
         height_ff <= CFG_DIM_W'(RST_HEIGHT);
         gain_ff   <= GAIN_W'(RST_GAIN);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[CFG_DIM_W-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[CFG_DIM_W-1:0];
            CSR_SHARPEN_GAIN: gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   // count results promised but not yet popped
   always_comb begin
      credit_in = credit_ff;
      if (emit && !rsp_take) begin
         credit_in = credit_ff + CRED_W'(1);
      end else if (!emit && rsp_take) begin
         credit_in = credit_ff - CRED_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   bbum_front #(
      .KERNEL    (KERNEL),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .cmd          (req_cmd),
      .pixel        ({req_red_in, req_green_in, req_blue_in}),
      .image_width  (width_ff),
      .image_height (height_ff),
      .emit         (emit),
      .job_valid    (fr_valid),
      .job_sum      (fr_sum),
      .job_src      (fr_src),
      .job_flags    (fr_flags)
   );

   bbum_fifo #(
      .WIDTH (JOB_W),
      .DEPTH (JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data ({fr_sum, fr_src, fr_flags}),
      .pop       (!jq_empty),
      .empty     (jq_empty),
      .head_data (jq_head)
   );

   assign bk_valid = !jq_empty;
   assign {bk_sum, bk_src, bk_flags} = jq_head;

   bbum_back #(
      .KERNEL (KERNEL)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (bk_valid),
      .job_sum       (bk_sum),
      .job_src       (bk_src),
      .job_flags     (bk_flags),
      .sharpen_gain  (gain_ff),
      .res_valid     (res_valid),
      .res_pixel     (res_pixel),
      .res_frame_end (res_frame_end)
   );

   bbum_fifo #(
      .WIDTH (RES_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data ({res_frame_end, res_pixel}),
      .pop       (pop),
      .empty     (empty),
      .head_data (oq_head)
   );

   assign {rsp_frame_end, rsp_red_out, rsp_green_out, rsp_blue_out} = oq_head;

`ifndef ASSERT_OFF
   a_result_promised : assert property (@(posedge clock) disable iff (reset)
      !empty |-> credit_ff != '0)
      else $error("result waiting without a promise");

   a_back_promised : assert property (@(posedge clock) disable iff (reset)
      res_valid |-> credit_ff != '0)
      else $error("back end produced an unpromised result");

   a_flush_no_grow : assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_FLUSH && !emit) |=> credit_ff <= $past(credit_ff))
      else $error("ignored flush changed outstanding count");
`endif

endmodule

/* sim/box_blur_unsharp_mask_tb.sv */
// Self-checking testbench for the box blur unsharp mask block.
`timescale 1ns / 100ps

module box_blur_unsharp_mask_tb;
   import bbum_pkg::*;

   localparam int KER   = DEF_KERNEL;
   localparam int MAXW  = DEF_MAX_WIDTH;
   localparam int HALF  = KER / 2;
   localparam int TAIL  = KER - 1 - KER / 2;
   localparam int DEPTH = (KER - 1) * MAXW + KER;

   typedef struct {
      logic            cmd;
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } pixel_req_type;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      logic            frame_end;
   } sharp_pixel_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic                  req_cmd = CMD_PIXEL;
   logic [CH_W-1:0]       req_red_in = '0;
   logic [CH_W-1:0]       req_green_in = '0;
   logic [CH_W-1:0]       req_blue_in = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic [CH_W-1:0]       rsp_red_out;
   logic [CH_W-1:0]       rsp_green_out;
   logic [CH_W-1:0]       rsp_blue_out;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   box_blur_unsharp_mask dut (.*);

   pixel_req_type   pending_reqs[$];
   sharp_pixel_type sharpened_q[$];
   pixel_req_type   cur_req;
   int              queued_count = 0;
   int              accepted_count = 0;
   int              mismatch_count = 0;
   int              idle_mode = 0;
   logic            rx_hold = 1'b0;

   // sharpener state
   logic [PIX_W-1:0] pixel_hist[DEPTH];
   int unsigned reg_width = RST_WIDTH, reg_height = RST_HEIGHT, reg_gain = RST_GAIN;
   int unsigned frame_w = RST_WIDTH, frame_h = RST_HEIGHT;
   int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
   int unsigned wr_ptr = 0, in_flight = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic emit_sharpened();
      int unsigned  a0, addr, src, sum, blur, diff, v;
      logic         inner;
      sharp_pixel_type res;
      logic [CH_W-1:0] chv[CH_COUNT];
      a0 = (wr_ptr + DEPTH - in_flight) % DEPTH;
      inner = out_row >= HALF && out_row + TAIL < frame_h &&
              out_col >= HALF && out_col + TAIL < frame_w;
      for (int ch = 0; ch < CH_COUNT; ch++) begin
         src = pixel_hist[a0][(CH_COUNT - 1 - ch) * CH_W +: CH_W];
         v = src;
         if (inner) begin
            sum = 0;
            for (int dr = 0; dr < KER; dr++) begin
               for (int dc = 0; dc < KER; dc++) begin
                  addr = (a0 + DEPTH + (dr - HALF) * int'(frame_w) + (dc - HALF)) % DEPTH;
                  sum += pixel_hist[addr][(CH_COUNT - 1 - ch) * CH_W +: CH_W];
               end
            end
            blur = sum / (KER * KER);
            diff = src > blur ? src - blur : 0;
            v = src + ((reg_gain * diff + ROUND_HALF) >> GAIN_FRAC);
            if (v > CH_MAX) v = CH_MAX;
         end
         chv[ch] = v[CH_W-1:0];
      end
      res.red = chv[0];
      res.green = chv[1];
      res.blue = chv[2];
      res.frame_end = (out_row == frame_h - 1 && out_col == frame_w - 1);
      sharpened_q.push_back(res);
      out_col++;
      if (out_col >= frame_w) begin
         out_col = 0;
         out_row++;
         if (out_row >= frame_h) out_row = 0;
      end
      in_flight--;
   endtask

   task automatic sharpen_model(input pixel_req_type q);
      logic at_bound;
      at_bound = (in_row == 0 && in_col == 0);
      if (q.cmd == CMD_PIXEL) begin
         if (at_bound && in_flight == 0) begin
            frame_w = clamp_dim(reg_width, MAXW);
            frame_h = clamp_dim(reg_height, MAX_HEIGHT);
         end
         pixel_hist[wr_ptr] = {q.red, q.green, q.blue};
         wr_ptr = (wr_ptr + 1) % DEPTH;
         in_col++;
         if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
            if (in_row >= frame_h) in_row = 0;
         end
         in_flight++;
         if (in_flight > TAIL * frame_w + TAIL) emit_sharpened();
      end else if (at_bound && in_flight > 0) begin
         emit_sharpened();
      end
   endtask

   function automatic logic roll_idle(int pct);
      return $urandom_range(99) < pct;
   endfunction

   // driver: hold the request until accepted, then advance
   always @(posedge clock) begin
      if (reset) begin
         push <= 1'b0;
      end else begin
         if (push && !full) begin
            sharpen_model(cur_req);
            accepted_count++;
         end
         if (!push || !full) begin
            if (pending_reqs.size() > 0 &&
                !roll_idle(idle_mode == 0 ? 15 : idle_mode == 1 ? 60 : 0)) begin
               cur_req = pending_reqs.pop_front();
               push <= 1'b1;
               req_cmd <= cur_req.cmd;
               req_red_in <= cur_req.red;
               req_green_in <= cur_req.green;
               req_blue_in <= cur_req.blue;
            end else begin
               push <= 1'b0;
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // monitor
   always @(posedge clock) begin
      sharp_pixel_type want;
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) begin
            if (sharpened_q.size() == 0) begin
               report_mismatch("unexpected result, frame_end", rsp_frame_end, 0);
            end else begin
               want = sharpened_q.pop_front();
               if (rsp_red_out !== want.red) report_mismatch("red", rsp_red_out, want.red);
               if (rsp_green_out !== want.green)
                  report_mismatch("green", rsp_green_out, want.green);
               if (rsp_blue_out !== want.blue) report_mismatch("blue", rsp_blue_out, want.blue);
               if (rsp_frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_frame_end, want.frame_end);
            end
         end
         pop <= !rx_hold && !roll_idle(idle_mode == 0 ? 60 : idle_mode == 1 ? 15 : 0);
      end
   end

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_IMAGE_WIDTH:  reg_width = value & 12'h7FF;
         CSR_IMAGE_HEIGHT: reg_height = value & 12'h7FF;
         CSR_SHARPEN_GAIN: reg_gain = value & 12'hFFF;
         default: ;
      endcase
   endtask

   task automatic set_regs(input int unsigned w, input int unsigned h, input int unsigned g);
      write_csr(CSR_IMAGE_WIDTH, w);
      write_csr(CSR_IMAGE_HEIGHT, h);
      write_csr(CSR_SHARPEN_GAIN, g);
   endtask

   task automatic add_req(input logic cmd, input logic [PIX_W-1:0] rgb);
      pixel_req_type q;
      q.cmd = cmd;
      {q.red, q.green, q.blue} = rgb;
      pending_reqs.push_back(q);
      queued_count++;
   endtask

   // pattern 1: checkerboard of magenta and green with a white pixel at row 1, column 1, else random
   task automatic add_frame(input int unsigned fw, input int unsigned fh, input int pattern,
                            input int noise_pct);
      for (int r = 0; r < fh; r++) begin
         for (int c = 0; c < fw; c++) begin
            if (pattern == 1)
               add_req(CMD_PIXEL, (r == 1 && c == 1) ? 24'hFFFFFF :
                                  ((r + c) % 2 ? 24'hFF00FF : 24'h00FF00));
            else
               add_req(CMD_PIXEL, PIX_W'($urandom()));
            // flush in mid-frame is dropped by the block
            if (r * fw + c + 1 < fw * fh && roll_idle(noise_pct))
               add_req(CMD_FLUSH, PIX_W'($urandom()));
         end
      end
   endtask

   task automatic add_flushes(input int n);
      repeat (n) add_req(CMD_FLUSH, PIX_W'($urandom()));
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (accepted_count != queued_count || sharpened_q.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      int unsigned w, h, g, fw, fh, nfr, rand_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // smallest frame, maximum gain, flush with nothing pending
      set_regs(3, 3, 4095);
      add_flushes(1);
      add_frame(3, 3, 1, 30);
      add_flushes(TAIL * 3 + TAIL + 1);
      wait_idle();

      // width and height below range, zero gain
      set_regs(0, 1, 0);
      add_frame(3, 3, 0, 0);
      add_flushes(TAIL * 3 + TAIL);
      wait_idle();

      rand_items = 0;
      while (rand_items < 400) begin
         idle_mode = rand_items < 133 ? 0 : rand_items < 266 ? 1 : 2;
         if (rand_items == 0) begin
            w = 12;
            h = 8;
            nfr = 2;
         end else begin
            w = $urandom_range(0, 12);
            h = $urandom_range(1, 7);
            nfr = $urandom_range(1, 3);
         end
         case ($urandom_range(3))
            0: g = 0;
            1: g = 4095;
            default: g = $urandom_range(0, 4095);
         endcase
         fw = clamp_dim(w, MAXW);
         fh = clamp_dim(h, MAX_HEIGHT);
         set_regs(w, h, g);
         for (int f = 0; f < nfr; f++) begin
            add_frame(fw, fh, 0, 5);
            // back-to-back frames push out the previous tail
            if (f == nfr - 1 || roll_idle(50))
               add_flushes(TAIL * fw + TAIL + $urandom_range(0, 1));
         end
         rand_items += queued_count - accepted_count;
         if (rand_items == queued_count - accepted_count) begin
            // starve the output so the block backs up on its input
            @(negedge clock);
            rx_hold = 1'b1;
            repeat (300) @(negedge clock);
            rx_hold = 1'b0;
         end
         wait_idle();
      end

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
